// ===== rtl/core/bpd_pkg.sv =====
// shared constants for the box point distance block
`timescale 1ns / 1ps
package bpd_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;
endpackage

// ===== rtl/core/bpd_sqrt.sv =====
// pipelined floor square root, one root bit per stage, with side payload
`timescale 1ns / 1ps
module bpd_sqrt #(
    parameter int ROOT_W = 32,
    parameter int PAY_W  = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic [2*ROOT_W-1:0]   rad,
    input  logic [PAY_W-1:0]      pay_in,
    output logic                  vld_out,
    output logic [ROOT_W-1:0]     root,
    output logic [PAY_W-1:0]      pay_out
);
    localparam int IN_W = 2 * ROOT_W;

    logic [IN_W-1:0]   rem_in   [ROOT_W];
    logic [ROOT_W-1:0] root_in  [ROOT_W];
    logic [PAY_W-1:0]  pay_in_s [ROOT_W];
    logic              vld_in_s [ROOT_W];
    logic [IN_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [PAY_W-1:0]  pay_reg  [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [IN_W-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in[k]   = rad;
            assign root_in[k]  = '0;
            assign pay_in_s[k] = pay_in;
            assign vld_in_s[k] = vld_in;
        end else begin : g_next
            assign rem_in[k]   = rem_reg[k-1];
            assign root_in[k]  = root_reg[k-1];
            assign pay_in_s[k] = pay_reg[k-1];
            assign vld_in_s[k] = vld_reg[k-1];
        end

        // (r + 2^i)^2 - r^2 with r holding only bits above i
        assign trial = (IN_W'(root_in[k]) << (BIT + 1)) | (IN_W'(1) << (2 * BIT));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pay_reg[k] <= pay_in_s[k];
                if (rem_in[k] >= trial)
                begin
                    rem_reg[k]  <= rem_in[k] - trial;
                    root_reg[k] <= root_in[k] | (ROOT_W'(1) << BIT);
                end
                else
                begin
                    rem_reg[k]  <= rem_in[k];
                    root_reg[k] <= root_in[k];
                end
            end
        end
    end

    assign vld_out = vld_reg[ROOT_W-1];
    assign root    = root_reg[ROOT_W-1];
    assign pay_out = pay_reg[ROOT_W-1];
endmodule

// ===== rtl/core/bpd_lane.sv =====
// one world axis: half extent from an axis vector, then the offset beyond it
`timescale 1ns / 1ps
module bpd_lane #(
    parameter int COORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   vld_in,
    input  logic [COORD_BITS-1:0]  cam,
    input  logic [COORD_BITS-1:0]  ctr,
    input  logic [COORD_BITS-1:0]  ax,
    input  logic [COORD_BITS-1:0]  ay,
    input  logic [COORD_BITS-1:0]  az,
    output logic                   vld_out,
    output logic [COORD_BITS:0]    excess
);
    localparam int C  = COORD_BITS;
    localparam int SQ = 2 * C;

    logic [C:0]    diff;
    logic [C-1:0]  ax_m_reg, ay_m_reg, az_m_reg;
    logic [C:0]    off_a_reg, off_b_reg, off_c_reg, off_s;
    logic [SQ-1:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;
    logic          vld_a_reg, vld_b_reg, vld_c_reg, vld_s;
    logic [C-1:0]  ext;
    logic [C:0]    excess_reg;
    logic          vld_e_reg;

    function automatic logic [C-1:0] mag_c(input logic [C-1:0] v);
        return v[C-1] ? (~v + C'(1)) : v;
    endfunction

    assign diff = {cam[C-1], cam} - {ctr[C-1], ctr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= vld_in;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_e_reg <= vld_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_m_reg   <= mag_c(ax);
            ay_m_reg   <= mag_c(ay);
            az_m_reg   <= mag_c(az);
            off_a_reg  <= diff[C] ? (~diff + (C+1)'(1)) : diff;
            sqx_reg    <= ax_m_reg * ax_m_reg;
            sqy_reg    <= ay_m_reg * ay_m_reg;
            sqz_reg    <= az_m_reg * az_m_reg;
            off_b_reg  <= off_a_reg;
            sum_reg    <= sqx_reg + sqy_reg + sqz_reg;
            off_c_reg  <= off_b_reg;
            excess_reg <= (off_s > (C+1)'(ext)) ? off_s - (C+1)'(ext) : '0;
        end
    end

    bpd_sqrt #(
        .ROOT_W (C),
        .PAY_W  (C + 1)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vld_c_reg),
        .rad     (sum_reg),
        .pay_in  (off_c_reg),
        .vld_out (vld_s),
        .root    (ext),
        .pay_out (off_s)
    );

    assign vld_out = vld_e_reg;
    assign excess  = excess_reg;
endmodule

// ===== rtl/core/bpd_merge.sv =====
// merges the three lane offsets into one euclidean length
`timescale 1ns / 1ps
module bpd_merge #(
    parameter int COORD_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic [COORD_BITS:0]   dx,
    input  logic [COORD_BITS:0]   dy,
    input  logic [COORD_BITS:0]   dz,
    output logic                  vld_out,
    output logic [COORD_BITS:0]   dist_len
);
    localparam int RW = COORD_BITS + 1;
    localparam int SQ = 2 * RW;

    logic [SQ-1:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;
    logic          nz_a_reg, nz_b_reg, nz_s;
    logic          vld_a_reg, vld_b_reg;
    logic [RW-1:0] root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= vld_in;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= dx * dx;
            sqy_reg  <= dy * dy;
            sqz_reg  <= dz * dz;
            nz_a_reg <= (dx != '0) || (dy != '0) || (dz != '0);
            sum_reg  <= sqx_reg + sqy_reg + sqz_reg;
            nz_b_reg <= nz_a_reg;
        end
    end

    bpd_sqrt #(
        .ROOT_W (RW),
        .PAY_W  (1)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vld_b_reg),
        .rad     (sum_reg),
        .pay_in  (nz_b_reg),
        .vld_out (vld_out),
        .root    (root),
        .pay_out (nz_s)
    );

    // inside the box every offset is zero
    assign dist_len = nz_s ? root : '0;
endmodule

// ===== rtl/core/box_point_distance.sv =====
// top level: distance from the camera point to an oriented box
//
//  port group   dir  handshake             payload
//  in           in   in_valid / in_ready   center_*, axis_a_*, axis_b_*, axis_c_*
//  out          out  out_valid / out_ready distance
//  cfg          in   cfg_we                cfg_index, cfg_data
//
// one word per cycle in and out unless the output stalls; the path runs through
// the two bit-per-stage square root pipelines
// reset clears the camera point to zero and empties the pipeline
// the whole pipeline holds while a result waits on out_ready
`timescale 1ns / 1ps
module box_point_distance
    import bpd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] center_x,
    input  logic [COORD_BITS-1:0] center_y,
    input  logic [COORD_BITS-1:0] center_z,
    input  logic [COORD_BITS-1:0] axis_a_x,
    input  logic [COORD_BITS-1:0] axis_a_y,
    input  logic [COORD_BITS-1:0] axis_a_z,
    input  logic [COORD_BITS-1:0] axis_b_x,
    input  logic [COORD_BITS-1:0] axis_b_y,
    input  logic [COORD_BITS-1:0] axis_b_z,
    input  logic [COORD_BITS-1:0] axis_c_x,
    input  logic [COORD_BITS-1:0] axis_c_y,
    input  logic [COORD_BITS-1:0] axis_c_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS:0]   distance,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);
    logic [COORD_BITS-1:0] camera_x_reg, camera_y_reg, camera_z_reg;
    logic                  en;
    logic                  vld_x, vld_y, vld_z, vld_m;
    logic [COORD_BITS:0]   dx, dy, dz, dist_m;
    logic                  out_valid_reg;
    logic [COORD_BITS:0]   distance_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg <= '0;
            camera_y_reg <= '0;
            camera_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAMERA_X: camera_x_reg <= cfg_data;
                CFG_CAMERA_Y: camera_y_reg <= cfg_data;
                CFG_CAMERA_Z: camera_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bpd_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (in_valid),
        .cam (camera_x_reg), .ctr (center_x),
        .ax (axis_a_x), .ay (axis_a_y), .az (axis_a_z),
        .vld_out (vld_x), .excess (dx)
    );

    bpd_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (in_valid),
        .cam (camera_y_reg), .ctr (center_y),
        .ax (axis_b_x), .ay (axis_b_y), .az (axis_b_z),
        .vld_out (vld_y), .excess (dy)
    );

    bpd_lane #(.COORD_BITS(COORD_BITS)) u_lane_z (
        .clk (clk), .rst_n (rst_n), .en (en), .vld_in (in_valid),
        .cam (camera_z_reg), .ctr (center_z),
        .ax (axis_c_x), .ay (axis_c_y), .az (axis_c_z),
        .vld_out (vld_z), .excess (dz)
    );

    bpd_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .clk (clk), .rst_n (rst_n), .en (en),
        .vld_in (vld_x && vld_y && vld_z),
        .dx (dx), .dy (dy), .dz (dz),
        .vld_out (vld_m), .dist_len (dist_m)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_m;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            distance_reg <= dist_m;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled without a waiting word");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_x == vld_y) && (vld_y == vld_z))
        else $error("lane valids out of step");

    a_cam_x_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == CFG_CAMERA_X |=> camera_x_reg == $past(cfg_data))
        else $error("camera x write lost");

    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(camera_x_reg) && $stable(camera_y_reg)
            && $stable(camera_z_reg))
        else $error("camera point changed without a write");
endmodule

// ===== verif/tb.sv =====
// testbench for box_point_distance: random and directed boxes against a bit-exact predictor
`timescale 1ns / 1ps
module tb;
    import bpd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int LATENCY = 2 * COORD_BITS_DEF + 8;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [31:0] center_x, center_y, center_z;
        logic [31:0] axis_a_x, axis_a_y, axis_a_z;
        logic [31:0] axis_b_x, axis_b_y, axis_b_z;
        logic [31:0] axis_c_x, axis_c_y, axis_c_z;
    } box_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [32:0] distance;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CAMERA_X;
    logic [31:0] cfg_data = '0;
    box_t offered = '0;

    logic [31:0] cam_x = '0, cam_y = '0, cam_z = '0;
    box_t box_q[$];
    logic [32:0] dist_q[$];
    int errors = 0;
    bit calm = 0;
    bit want_hold = 0;
    bit hold_done = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    box_point_distance dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .center_x(offered.center_x), .center_y(offered.center_y),
        .center_z(offered.center_z),
        .axis_a_x(offered.axis_a_x), .axis_a_y(offered.axis_a_y),
        .axis_a_z(offered.axis_a_z),
        .axis_b_x(offered.axis_b_x), .axis_b_y(offered.axis_b_y),
        .axis_b_z(offered.axis_b_z),
        .axis_c_x(offered.axis_c_x), .axis_c_y(offered.axis_c_y),
        .axis_c_z(offered.axis_c_z),
        .out_valid(out_valid), .out_ready(out_ready), .distance(distance),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0] r;
        logic [127:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = {64'b0, r | (64'b1 << i)};
            if (c * c <= n)
                r = c[63:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] length3(logic [63:0] x, logic [63:0] y, logic [63:0] z);
        logic [127:0] wx, wy, wz;
        wx = {64'b0, x};
        wy = {64'b0, y};
        wz = {64'b0, z};
        return floor_root(wx * wx + wy * wy + wz * wz);
    endfunction

    function automatic logic [63:0] abs32(logic [31:0] v);
        logic [63:0] s;
        s = {{32{v[31]}}, v};
        return s[63] ? -s : s;
    endfunction

    function automatic logic [63:0] beyond(logic [31:0] cam, logic [31:0] ctr, logic [63:0] ext);
        logic [63:0] d;
        d = {{32{cam[31]}}, cam} - {{32{ctr[31]}}, ctr};
        if (d[63])
            d = -d;
        return d > ext ? d - ext : 64'd0;
    endfunction

    function automatic logic [32:0] box_distance(box_t b);
        logic [63:0] ea, eb, ec, lenv;
        ea = length3(abs32(b.axis_a_x), abs32(b.axis_a_y), abs32(b.axis_a_z));
        eb = length3(abs32(b.axis_b_x), abs32(b.axis_b_y), abs32(b.axis_b_z));
        ec = length3(abs32(b.axis_c_x), abs32(b.axis_c_y), abs32(b.axis_c_z));
        lenv = length3(beyond(cam_x, b.center_x, ea), beyond(cam_y, b.center_y, eb),
                       beyond(cam_z, b.center_z, ec));
        return lenv[32:0];
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        box_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                dist_q.push_back(box_distance(offered));
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (box_q.size() > 0)
            begin
                nxt = box_q.pop_front();
                offered <= nxt;
                in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic [32:0] want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (dist_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual distance %h",
                             $time, distance);
                    errors++;
                end
                else
                begin
                    want = dist_q.pop_front();
                    if (distance !== want)
                    begin
                        $display("%0t: distance mismatch, expected %h, actual %h",
                                 $time, want, distance);
                        errors++;
                    end
                end
            end
            if (want_hold && !hold_done)
            begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("box_point_distance regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_CAMERA_X: cam_x = val;
            CFG_CAMERA_Y: cam_y = val;
            CFG_CAMERA_Z: cam_z = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        write_reg(CFG_CAMERA_X, x);
        write_reg(CFG_CAMERA_Y, y);
        write_reg(CFG_CAMERA_Z, z);
    endtask

    task automatic drain();
        while (box_q.size() > 0 || in_valid || dist_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
        endcase
    endfunction

    function automatic box_t random_box();
        box_t b;
        int mode;
        mode = $urandom_range(0, 9);
        mode = mode < 4 ? 0 : mode < 8 ? 1 : mode == 8 ? 2 : 3;
        b.axis_a_x = pick_coord(mode);
        b.axis_a_y = pick_coord(mode);
        b.axis_a_z = pick_coord(mode);
        b.axis_b_x = pick_coord(mode);
        b.axis_b_y = pick_coord(mode);
        b.axis_b_z = pick_coord(mode);
        b.axis_c_x = pick_coord(mode);
        b.axis_c_y = pick_coord(mode);
        b.axis_c_z = pick_coord(mode);
        if ($urandom_range(0, 1))
        begin
            // center near the camera so some boxes enclose it
            b.center_x = cam_x + pick_coord(1);
            b.center_y = cam_y + pick_coord(1);
            b.center_z = cam_z + pick_coord(1);
        end
        else
        begin
            b.center_x = pick_coord(mode);
            b.center_y = pick_coord(mode);
            b.center_z = pick_coord(mode);
        end
        return b;
    endfunction

    task automatic random_phase(int n);
        repeat (n) box_q.push_back(random_box());
    endtask

    function automatic box_t uniform_box(logic [31:0] ctr, logic [31:0] ax);
        return '{ctr, ctr, ctr, ax, ax, ax, ax, ax, ax, ax, ax, ax};
    endfunction

    initial
    begin
        box_t b;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: camera at origin
        box_q.push_back('0);
        box_q.push_back(uniform_box(32'h0, 32'h0001_0000));
        box_q.push_back(uniform_box(32'h7fff_ffff, 32'h0));
        box_q.push_back(uniform_box(32'h8000_0000, 32'h0));
        box_q.push_back(uniform_box(32'h8000_0000, 32'h8000_0000));
        box_q.push_back(uniform_box(32'h7fff_ffff, 32'h7fff_ffff));
        box_q.push_back(uniform_box(32'hffff_ffff, 32'hffff_ffff));
        box_q.push_back('1);
        b = '0;
        b.center_x = 32'h0002_0000;
        b.axis_a_x = 32'hfffe_0000;
        box_q.push_back(b);
        b.center_y = 32'h0003_0000;
        box_q.push_back(b);
        drain();

        // directed: camera at extremes, boxes at extreme and zero centers
        set_camera(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        box_q.push_back(uniform_box(32'h8000_0000, 32'h0));
        box_q.push_back(uniform_box(32'h7fff_ffff, 32'h0));
        box_q.push_back(uniform_box(32'h8000_0000, 32'h8000_0000));
        b = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
              32'h0, 32'h0, 32'h0};
        box_q.push_back(b);
        box_q.push_back(uniform_box(32'h0, 32'h5555_aaaa));
        drain();

        set_camera(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        random_phase(120);
        drain();

        // long receiver hold while items are still being offered
        set_camera($urandom, $urandom, $urandom);
        random_phase(200);
        want_hold = 1;
        drain();

        set_camera(pick_coord(1), pick_coord(1), pick_coord(1));
        random_phase(150);
        drain();

        calm = 1;
        set_camera(32'h0, 32'hffff_ffff, 32'h0001_0000);
        random_phase(130);
        drain();

        if (errors == 0)
            $display("box_point_distance regression: pass");
        else
            $display("box_point_distance regression: fail");
        $finish;
    end
endmodule
